[design/msx_pkg.sv]
`default_nettype none
package msx_pkg;

	// Machine dimensions; all are powers of two so index wrap is a plain truncation.
	localparam int REGISTER_COUNT = 32;
	localparam int MEMORY_WORDS   = 4096;
	localparam int PROGRAM_DEPTH  = 1024;
	localparam int QUEUE_DEPTH    = 4;
	localparam int BYTES_PER_WORD = 4;

	localparam int REG_W   = $clog2(REGISTER_COUNT);
	localparam int MEM_AW  = $clog2(MEMORY_WORDS);
	localparam int PC_W    = $clog2(PROGRAM_DEPTH);
	localparam int BYTE_SH = $clog2(BYTES_PER_WORD);

	localparam logic [31:0] RESET_R0 = 32'd2000;

	// Instruction kind codes as they arrive on the input.
	localparam logic [4:0] KIND_NOP  = 5'd0;
	localparam logic [4:0] KIND_MOV  = 5'd1;
	localparam logic [4:0] KIND_ADD  = 5'd2;
	localparam logic [4:0] KIND_ADDI = 5'd3;
	localparam logic [4:0] KIND_SUB  = 5'd4;
	localparam logic [4:0] KIND_SUBI = 5'd5;
	localparam logic [4:0] KIND_AND  = 5'd6;
	localparam logic [4:0] KIND_ANDI = 5'd7;
	localparam logic [4:0] KIND_OR   = 5'd8;
	localparam logic [4:0] KIND_ORI  = 5'd9;
	localparam logic [4:0] KIND_XOR  = 5'd10;
	localparam logic [4:0] KIND_NOR  = 5'd11;
	localparam logic [4:0] KIND_SLL  = 5'd12;
	localparam logic [4:0] KIND_SRL  = 5'd13;
	localparam logic [4:0] KIND_SRA  = 5'd14;
	localparam logic [4:0] KIND_LW   = 5'd15;
	localparam logic [4:0] KIND_SW   = 5'd16;
	localparam logic [4:0] KIND_J    = 5'd17;
	localparam logic [4:0] KIND_JR   = 5'd18;
	localparam logic [4:0] KIND_BEQ  = 5'd19;
	localparam logic [4:0] KIND_BNE  = 5'd20;

	typedef enum logic [4:0] {
		OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_NOR,
		OP_SLL, OP_SRL, OP_SRA, OP_LW, OP_SW, OP_J, OP_JR, OP_BEQ, OP_BNE, OP_RET
	} op_t;

	typedef struct packed {
		logic [4:0]          kind;
		logic                is_return;
		logic [4:0]          dest_reg;
		logic [4:0]          src_reg;
		logic [4:0]          src2_reg;
		logic signed [15:0]  immediate;
		logic [9:0]          target_index;
	} instr_t;

	typedef struct packed {
		logic [9:0]          next_pc;
		logic                write_valid;
		logic [4:0]          write_reg;
		logic signed [31:0]  write_value;
		logic                halted;
		logic signed [31:0]  return_value;
	} result_t;

	// Classified instruction as it sits in the queue.
	typedef struct packed {
		op_t              op;
		logic             use_imm;
		logic [REG_W-1:0] dst;
		logic [REG_W-1:0] rs_a;
		logic [REG_W-1:0] rs_b;
		logic [31:0]      imm;
		logic [31:0]      mem_off;
		logic [4:0]       shamt;
		logic [PC_W-1:0]  target;
	} decoded_t;

	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] idx;
		logic [31:0]      data;
	} rf_write_t;

endpackage
`default_nettype wire

[design/msx_stream_if.sv]
`default_nettype none
interface msx_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/msx_front.sv]
`default_nettype none
module msx_front (
	msx_stream_if.sink        instr,
	input  wire logic         push_ready,
	output logic              push_valid,
	output msx_pkg::decoded_t push_data
);

	msx_pkg::instr_t     in_w;
	logic signed [15:0]  imm_adj;

	assign in_w         = instr.data;
	assign instr.ready  = push_ready;
	assign push_valid   = instr.valid;

	// Byte offset to word offset, rounded toward zero for negative offsets.
	assign imm_adj = in_w.immediate
		+ (in_w.immediate[15] ? 16'(msx_pkg::BYTES_PER_WORD - 1) : 16'sd0);

	always_comb begin
		push_data         = '0;
		push_data.op      = msx_pkg::OP_NOP;
		push_data.use_imm = 1'b0;
		push_data.dst     = in_w.dest_reg[msx_pkg::REG_W-1:0];
		push_data.rs_a    = in_w.src_reg[msx_pkg::REG_W-1:0];
		push_data.rs_b    = in_w.src2_reg[msx_pkg::REG_W-1:0];
		push_data.imm     = 32'(in_w.immediate);
		push_data.mem_off = 32'(imm_adj >>> msx_pkg::BYTE_SH);
		push_data.shamt   = in_w.immediate[4:0];
		push_data.target  = in_w.target_index[msx_pkg::PC_W-1:0];

		case (in_w.kind)
			msx_pkg::KIND_MOV:  push_data.op = msx_pkg::OP_MOV;
			msx_pkg::KIND_ADD:  push_data.op = msx_pkg::OP_ADD;
			msx_pkg::KIND_ADDI: begin
				push_data.op      = msx_pkg::OP_ADD;
				push_data.use_imm = 1'b1;
			end
			msx_pkg::KIND_SUB:  push_data.op = msx_pkg::OP_SUB;
			msx_pkg::KIND_SUBI: begin
				push_data.op      = msx_pkg::OP_SUB;
				push_data.use_imm = 1'b1;
			end
			msx_pkg::KIND_AND:  push_data.op = msx_pkg::OP_AND;
			msx_pkg::KIND_ANDI: begin
				push_data.op      = msx_pkg::OP_AND;
				push_data.use_imm = 1'b1;
			end
			msx_pkg::KIND_OR:   push_data.op = msx_pkg::OP_OR;
			msx_pkg::KIND_ORI:  begin
				push_data.op      = msx_pkg::OP_OR;
				push_data.use_imm = 1'b1;
			end
			msx_pkg::KIND_XOR:  push_data.op = msx_pkg::OP_XOR;
			msx_pkg::KIND_NOR:  push_data.op = msx_pkg::OP_NOR;
			msx_pkg::KIND_SLL:  push_data.op = msx_pkg::OP_SLL;
			msx_pkg::KIND_SRL:  push_data.op = msx_pkg::OP_SRL;
			msx_pkg::KIND_SRA:  push_data.op = msx_pkg::OP_SRA;
			msx_pkg::KIND_LW:   push_data.op = msx_pkg::OP_LW;
			msx_pkg::KIND_SW:   begin
				push_data.op   = msx_pkg::OP_SW;
				push_data.rs_b = in_w.dest_reg[msx_pkg::REG_W-1:0];
			end
			msx_pkg::KIND_J:    push_data.op = msx_pkg::OP_J;
			msx_pkg::KIND_JR:   begin
				push_data.op   = msx_pkg::OP_JR;
				push_data.rs_b = in_w.dest_reg[msx_pkg::REG_W-1:0];
			end
			msx_pkg::KIND_BEQ:  begin
				push_data.op   = msx_pkg::OP_BEQ;
				push_data.rs_b = in_w.dest_reg[msx_pkg::REG_W-1:0];
			end
			msx_pkg::KIND_BNE:  begin
				push_data.op   = msx_pkg::OP_BNE;
				push_data.rs_b = in_w.dest_reg[msx_pkg::REG_W-1:0];
			end
			default:            push_data.op = msx_pkg::OP_NOP;
		endcase

		// A return overrides whatever kind says.
		if (in_w.is_return) begin
			push_data.op   = msx_pkg::OP_RET;
			push_data.rs_b = in_w.dest_reg[msx_pkg::REG_W-1:0];
		end
	end

endmodule
`default_nettype wire

[design/msx_queue.sv]
`default_nettype none
module msx_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire msx_pkg::decoded_t push_data,
	output logic                   space,
	output logic                   head_valid,
	output msx_pkg::decoded_t      head,
	input  wire logic              pop
);

	localparam int PTR_W = $clog2(msx_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(msx_pkg::QUEUE_DEPTH + 1);

	msx_pkg::decoded_t entries [msx_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign space      = count_q != CNT_W'(msx_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entries[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= PTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= PTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop)
				count_q <= CNT_W'(count_q + 1'b1);
			else if (pop && !push)
				count_q <= CNT_W'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

[design/msx_regfile.sv]
`default_nettype none
module msx_regfile (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [msx_pkg::REG_W-1:0] addr_a,
	input  wire logic [msx_pkg::REG_W-1:0] addr_b,
	input  wire msx_pkg::rf_write_t        wr,
	output logic [31:0]                    rdata_a_q,
	output logic [31:0]                    rdata_b_q
);

	logic [31:0]                       regs [msx_pkg::REGISTER_COUNT];
	logic [msx_pkg::REGISTER_COUNT-1:0] written_q;

	function automatic logic [31:0] reset_value(input logic [msx_pkg::REG_W-1:0] idx);
		return (idx == '0) ? msx_pkg::RESET_R0 : 32'd0;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			written_q <= '0;
		else if (wr.en)
			written_q[wr.idx] <= 1'b1;
	end

	// Reads see a write landing at the same edge.
	always_ff @(posedge clk) begin
		if (wr.en)
			regs[wr.idx] <= wr.data;
		if (rd_en) begin
			if (wr.en && wr.idx == addr_a)
				rdata_a_q <= wr.data;
			else
				rdata_a_q <= written_q[addr_a] ? regs[addr_a] : reset_value(addr_a);
			if (wr.en && wr.idx == addr_b)
				rdata_b_q <= wr.data;
			else
				rdata_b_q <= written_q[addr_b] ? regs[addr_b] : reset_value(addr_b);
		end
	end

endmodule
`default_nettype wire

[design/msx_back.sv]
`default_nettype none
module msx_back (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [9:0]               cfg_wdata,
	input  wire logic                     head_valid,
	input  wire msx_pkg::decoded_t        head,
	output logic                          pop,
	output logic                          busy,
	msx_stream_if.source                  result
);

	localparam int MEM_AW = msx_pkg::MEM_AW;
	localparam int PC_W   = msx_pkg::PC_W;
	localparam int REG_W  = msx_pkg::REG_W;

	logic                 adv;
	logic                 valid_s2;
	msx_pkg::decoded_t    dec_s2;
	logic [31:0]          rda_s2;
	logic [31:0]          rdb_s2;

	logic                 valid_s3;
	logic                 wv_s3;
	logic                 load_s3;
	logic [REG_W-1:0]     wreg_s3;
	logic [31:0]          alu_s3;
	logic [PC_W-1:0]      npc_s3;
	logic                 halt_s3;
	logic [31:0]          ret_s3;

	logic [31:0]          dmem [msx_pkg::MEMORY_WORDS];
	logic [31:0]          mem_rd_q;
	logic                 clr_busy_q;
	logic [MEM_AW-1:0]    clr_addr_q;
	logic [PC_W-1:0]      pc_q;

	logic [31:0]          wb_val;
	logic [31:0]          va;
	logic [31:0]          vb;
	logic [31:0]          opnd;
	logic [31:0]          alu;
	logic [31:0]          addr_sum;
	logic [MEM_AW-1:0]    mem_addr;
	logic [PC_W-1:0]      npc;
	logic                 wv;
	msx_pkg::rf_write_t   rf_wr;

	// The whole back end moves together whenever the output register can take a word.
	assign adv  = !valid_s3 || result.ready;
	assign pop  = adv && head_valid && !clr_busy_q;
	assign busy = clr_busy_q;

	assign wb_val    = load_s3 ? mem_rd_q : alu_s3;
	assign rf_wr.en  = valid_s3 && result.ready && wv_s3;
	assign rf_wr.idx = wreg_s3;
	assign rf_wr.data = wb_val;

	msx_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (adv),
		.addr_a    (head.rs_a),
		.addr_b    (head.rs_b),
		.wr        (rf_wr),
		.rdata_a_q (rda_s2),
		.rdata_b_q (rdb_s2)
	);

	// Forward the result of the instruction one ahead, which has not reached the file yet.
	always_comb begin
		va = (valid_s3 && wv_s3 && wreg_s3 == dec_s2.rs_a) ? wb_val : rda_s2;
		vb = (valid_s3 && wv_s3 && wreg_s3 == dec_s2.rs_b) ? wb_val : rdb_s2;
		opnd = dec_s2.use_imm ? dec_s2.imm : vb;

		case (dec_s2.op)
			msx_pkg::OP_MOV: alu = va;
			msx_pkg::OP_ADD: alu = va + opnd;
			msx_pkg::OP_SUB: alu = va - opnd;
			msx_pkg::OP_AND: alu = va & opnd;
			msx_pkg::OP_OR:  alu = va | opnd;
			msx_pkg::OP_XOR: alu = va ^ vb;
			msx_pkg::OP_NOR: alu = ~(va | vb);
			msx_pkg::OP_SLL: alu = va << dec_s2.shamt;
			msx_pkg::OP_SRL: alu = va >> dec_s2.shamt;
			msx_pkg::OP_SRA: alu = 32'($signed(va) >>> dec_s2.shamt);
			default:         alu = '0;
		endcase

		wv = dec_s2.op inside {msx_pkg::OP_MOV, msx_pkg::OP_ADD, msx_pkg::OP_SUB,
			msx_pkg::OP_AND, msx_pkg::OP_OR, msx_pkg::OP_XOR, msx_pkg::OP_NOR,
			msx_pkg::OP_SLL, msx_pkg::OP_SRL, msx_pkg::OP_SRA, msx_pkg::OP_LW};

		addr_sum = va + dec_s2.mem_off;
		mem_addr = addr_sum[MEM_AW-1:0];

		case (dec_s2.op)
			msx_pkg::OP_J:   npc = dec_s2.target;
			msx_pkg::OP_JR:  npc = vb[PC_W-1:0];
			msx_pkg::OP_BEQ: npc = (vb == va) ? dec_s2.target : PC_W'(pc_q + 1'b1);
			msx_pkg::OP_BNE: npc = (vb != va) ? dec_s2.target : PC_W'(pc_q + 1'b1);
			msx_pkg::OP_RET: npc = pc_q;
			default:         npc = PC_W'(pc_q + 1'b1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			pc_q       <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= pop;
				valid_s3 <= valid_s2;
			end
			if (clr_busy_q) begin
				clr_addr_q <= MEM_AW'(clr_addr_q + 1'b1);
				if (clr_addr_q == MEM_AW'(msx_pkg::MEMORY_WORDS - 1))
					clr_busy_q <= 1'b0;
			end
			if (cfg_we)
				pc_q <= cfg_wdata[PC_W-1:0];
			else if (adv && valid_s2)
				pc_q <= npc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s2  <= head;
			wv_s3   <= wv;
			load_s3 <= dec_s2.op == msx_pkg::OP_LW;
			wreg_s3 <= dec_s2.dst;
			alu_s3  <= alu;
			npc_s3  <= npc;
			halt_s3 <= dec_s2.op == msx_pkg::OP_RET;
			ret_s3  <= (dec_s2.op == msx_pkg::OP_RET) ? vb : 32'd0;
		end
	end

	// A store writes at the edge it leaves execute, so a following load already sees it.
	always_ff @(posedge clk) begin
		if (clr_busy_q)
			dmem[clr_addr_q] <= '0;
		else if (adv && valid_s2 && dec_s2.op == msx_pkg::OP_SW)
			dmem[mem_addr] <= vb;
		if (adv && valid_s2)
			mem_rd_q <= dmem[mem_addr];
	end

	assign result.valid             = valid_s3;
	assign result.data.next_pc      = npc_s3;
	assign result.data.write_valid  = wv_s3;
	assign result.data.write_reg    = wv_s3 ? 5'(wreg_s3) : 5'd0;
	assign result.data.write_value  = wv_s3 ? wb_val : 32'd0;
	assign result.data.halted       = halt_s3;
	assign result.data.return_value = ret_s3;

endmodule
`default_nettype wire

[design/mips_subset_execute.sv]
`default_nettype none
// Executes one decoded instruction word per cycle, unless the queue or the output handshake
// holds it, for a small MIPS-like integer machine and returns one result word per instruction,
// in order. Instruction words are classified on entry and wait in a four-deep queue; the execute
// side runs a two-stage pipeline (register read, then execute with data memory access), with
// the output register as its last stage, so a result is offered from the output register once
// its instruction has passed the queue and the register-read stage. Back-to-back dependences
// are forwarded, including a load feeding the very next instruction, so the sustained rate is
// one instruction per cycle, limited only by the output handshake.
// After reset the 4096-word data memory is cleared one word per cycle, and no instruction is taken
// until the clearing pass is done; writes to start_pc are accepted at any time the block
// is idle and also load the program counter.
module mips_subset_execute (
	input  wire logic     clk,
	input  wire logic     arst_n,
	msx_stream_if.sink    instr,
	msx_stream_if.source  result,
	input  wire logic     cfg_we,
	input  wire logic [9:0] cfg_wdata
);

	logic              f_valid;
	msx_pkg::decoded_t f_data;
	logic              push_ok;
	logic              q_space;
	logic              q_head_valid;
	msx_pkg::decoded_t q_head;
	logic              q_pop;
	logic              back_busy;

	assign push_ok = q_space && !back_busy;

	msx_front u_front (
		.instr      (instr),
		.push_ready (push_ok),
		.push_valid (f_valid),
		.push_data  (f_data)
	);

	msx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (f_valid && push_ok),
		.push_data  (f_data),
		.space      (q_space),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop)
	);

	msx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.busy       (back_busy),
		.result     (result)
	);

endmodule
`default_nettype wire

[verif/mips_subset_execute_tb.sv]
module mips_subset_execute_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import msx_pkg::*;

	localparam logic [4:0] KIND_UNUSED_TOP = 5'd31;
	localparam int         DRAIN_CYCLES    = 10;
	localparam int         PHASE_ITEMS     = 275;
	localparam int         HOT_ADDRS       = 8;
	localparam int         SEND_IDLE [4]   = '{0, 80, 0, 29};
	localparam int         RECV_STALL [4]  = '{0, 0, 80, 29};

	typedef struct {
		instr_t  w;
		bit      typed;
		result_t want;
	} step_row_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [PC_W-1:0] cfg_wdata;

	msx_stream_if #(.payload_t(instr_t))  instr_ch ();
	msx_stream_if #(.payload_t(result_t)) result_ch ();

	mips_subset_execute dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.instr     (instr_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Architectural copy of the machine, advanced once per accepted instruction word.
	logic [31:0]       shadow_regs [REGISTER_COUNT];
	logic [31:0]       shadow_mem [MEMORY_WORDS];
	logic [PC_W-1:0]   shadow_pc;
	logic [MEM_AW-1:0] hot_addrs [HOT_ADDRS];
	result_t           pending_results [$];
	int                mismatches = 0;
	int                send_idle_pct = 0;
	int                stall_pct = 0;

	function automatic instr_t mk_instr(input logic [4:0] kind, input logic ret,
			input logic [4:0] d, input logic [4:0] s, input logic [4:0] t,
			input logic [15:0] imm, input logic [9:0] tgt);
		instr_t w;
		w.kind         = kind;
		w.is_return    = ret;
		w.dest_reg     = d;
		w.src_reg      = s;
		w.src2_reg     = t;
		w.immediate    = imm;
		w.target_index = tgt;
		return w;
	endfunction

	function automatic result_t mk_result(input logic [9:0] pc, input logic wv,
			input logic [4:0] wreg, input logic [31:0] wval, input logic h,
			input logic [31:0] rv);
		result_t r;
		r.next_pc      = pc;
		r.write_valid  = wv;
		r.write_reg    = wreg;
		r.write_value  = wval;
		r.halted       = h;
		r.return_value = rv;
		return r;
	endfunction

	function automatic result_t execute_instr(input instr_t w);
		result_t           r;
		logic [31:0]       vs;
		logic [31:0]       vt;
		logic [31:0]       vd;
		logic [31:0]       imm32;
		logic [31:0]       sum;
		logic [31:0]       wval;
		logic [MEM_AW-1:0] addr;
		logic [4:0]        sh;
		logic              wr;
		int                imm_i;
		int                off_words;
		vs        = shadow_regs[w.src_reg];
		vt        = shadow_regs[w.src2_reg];
		vd        = shadow_regs[w.dest_reg];
		imm_i     = int'(w.immediate);
		imm32     = imm_i;
		// Byte offset to word offset rounds toward zero, then the address wraps.
		off_words = imm_i / BYTES_PER_WORD;
		sum       = vs + off_words;
		addr      = sum[MEM_AW-1:0];
		sh        = w.immediate[4:0];
		r         = '0;
		r.next_pc = shadow_pc + 1'b1;
		wr        = 1'b1;
		wval      = '0;
		if (w.is_return) begin
			wr             = 1'b0;
			r.halted       = 1'b1;
			r.return_value = vd;
			r.next_pc      = shadow_pc;
		end else begin
			case (w.kind)
				KIND_MOV:  wval = vs;
				KIND_ADD:  wval = vs + vt;
				KIND_ADDI: wval = vs + imm32;
				KIND_SUB:  wval = vs - vt;
				KIND_SUBI: wval = vs - imm32;
				KIND_AND:  wval = vs & vt;
				KIND_ANDI: wval = vs & imm32;
				KIND_OR:   wval = vs | vt;
				KIND_ORI:  wval = vs | imm32;
				KIND_XOR:  wval = vs ^ vt;
				KIND_NOR:  wval = ~(vs | vt);
				KIND_SLL:  wval = vs << sh;
				KIND_SRL:  wval = vs >> sh;
				KIND_SRA:  wval = $signed(vs) >>> sh;
				KIND_LW:   wval = shadow_mem[addr];
				KIND_SW: begin
					shadow_mem[addr] = vd;
					wr = 1'b0;
				end
				KIND_J: begin
					r.next_pc = w.target_index;
					wr = 1'b0;
				end
				KIND_JR: begin
					r.next_pc = vd[PC_W-1:0];
					wr = 1'b0;
				end
				KIND_BEQ: begin
					if (vd == vs) r.next_pc = w.target_index;
					wr = 1'b0;
				end
				KIND_BNE: begin
					if (vd != vs) r.next_pc = w.target_index;
					wr = 1'b0;
				end
				default: wr = 1'b0;
			endcase
		end
		if (wr) begin
			shadow_regs[w.dest_reg] = wval;
			r.write_valid = 1'b1;
			r.write_reg   = w.dest_reg;
			r.write_value = wval;
		end
		shadow_pc = r.next_pc;
		return r;
	endfunction

	function automatic instr_t random_instr();
		instr_t            w;
		int                pick;
		logic [MEM_AW-1:0] k;
		w.kind         = 5'($urandom_range(KIND_BNE));
		w.is_return    = ($urandom_range(99) < 4);
		w.dest_reg     = 5'($urandom);
		w.src_reg      = 5'($urandom);
		w.src2_reg     = 5'($urandom);
		w.immediate    = 16'($urandom);
		w.target_index = 10'($urandom);
		pick = $urandom_range(99);
		if (pick < 8) begin
			w.kind = 5'($urandom_range(KIND_UNUSED_TOP, KIND_BNE + 1));
		end else if (pick < 28) begin
			// Aim loads and stores at a few shared words so that stores are read back.
			w.kind = pick[0] ? KIND_LW : KIND_SW;
			k = hot_addrs[$urandom_range(HOT_ADDRS - 1)] - shadow_regs[w.src_reg][MEM_AW-1:0];
			w.immediate = {2'b00, k, w.immediate[1:0]};
		end else if (pick < 36) begin
			w.kind = pick[0] ? KIND_BEQ : KIND_BNE;
			w.src_reg = w.dest_reg;
		end
		return w;
	endfunction

	task automatic send_instr(input instr_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			instr_ch.valid <= 1'b0;
			@(negedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.data  <= w;
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		instr_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_start_pc(input logic [PC_W-1:0] pc);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= pc;
		@(negedge clk);
		cfg_we    <= 1'b0;
		shadow_pc = pc;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_400_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (pending_results.size() == 0) begin
				$error("result word with no instruction outstanding: next_pc %0d", got.next_pc);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.next_pc !== want.next_pc) begin
					$error("next_pc: expected %0d, got %0d", want.next_pc, got.next_pc);
					mismatches++;
				end
				if (got.write_valid !== want.write_valid) begin
					$error("write_valid: expected %0d, got %0d", want.write_valid,
						got.write_valid);
					mismatches++;
				end
				if (got.write_reg !== want.write_reg) begin
					$error("write_reg: expected %0d, got %0d", want.write_reg, got.write_reg);
					mismatches++;
				end
				if (got.write_value !== want.write_value) begin
					$error("write_value: expected %0d, got %0d", want.write_value,
						got.write_value);
					mismatches++;
				end
				if (got.halted !== want.halted) begin
					$error("halted: expected %0d, got %0d", want.halted, got.halted);
					mismatches++;
				end
				if (got.return_value !== want.return_value) begin
					$error("return_value: expected %0d, got %0d", want.return_value,
						got.return_value);
					mismatches++;
				end
			end
		end
	end

	initial begin
		step_row_t       dir_rows [26];
		result_t         predicted;
		instr_t          w;
		logic [PC_W-1:0] entry_pc;

		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		instr_ch.valid = 1'b0;
		instr_ch.data  = '0;
		foreach (shadow_regs[i]) shadow_regs[i] = '0;
		foreach (shadow_mem[i]) shadow_mem[i] = '0;
		shadow_regs[0] = RESET_R0;
		shadow_pc = '0;
		hot_addrs[0] = '0;
		hot_addrs[1] = MEM_AW'(MEMORY_WORDS - 1);
		for (int i = 2; i < HOT_ADDRS; i++) hot_addrs[i] = MEM_AW'($urandom);

		// Rows from reset state; the first nine have results that follow directly.
		dir_rows = '{
			'{mk_instr(KIND_NOP, 1, 0, 0, 0, 16'h0000, 0), 1,
				mk_result(0, 0, 0, 0, 1, RESET_R0)},
			'{mk_instr(KIND_ADD, 1, 5, 0, 0, 16'h0000, 0), 1,
				mk_result(0, 0, 0, 0, 1, 0)},
			'{mk_instr(KIND_ADDI, 0, 1, 0, 0, 16'h7FFF, 0), 1,
				mk_result(1, 1, 1, 32'd34767, 0, 0)},
			'{mk_instr(KIND_ADDI, 0, 2, 31, 0, 16'h8000, 0), 1,
				mk_result(2, 1, 2, 32'hFFFF8000, 0, 0)},
			'{mk_instr(KIND_ORI, 0, 3, 31, 0, 16'hFFFF, 0), 1,
				mk_result(3, 1, 3, 32'hFFFFFFFF, 0, 0)},
			'{mk_instr(KIND_SUBI, 0, 4, 0, 0, 16'h0001, 0), 1,
				mk_result(4, 1, 4, 32'd1999, 0, 0)},
			'{mk_instr(KIND_J, 0, 0, 0, 0, 16'h0000, 10'h3FF), 1,
				mk_result(10'h3FF, 0, 0, 0, 0, 0)},
			'{mk_instr(KIND_NOP, 0, 31, 31, 31, 16'hFFFF, 10'h3FF), 1,
				mk_result(0, 0, 0, 0, 0, 0)},
			'{mk_instr(KIND_UNUSED_TOP, 0, 31, 31, 31, 16'hFFFF, 10'h3FF), 1,
				mk_result(1, 0, 0, 0, 0, 0)},
			'{mk_instr(KIND_MOV, 0, 6, 4, 0, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_ANDI, 0, 5, 3, 0, 16'h8000, 0), 0, '0},
			'{mk_instr(KIND_ADD, 0, 7, 1, 2, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_SUB, 0, 8, 2, 1, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_AND, 0, 9, 1, 3, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_OR, 0, 10, 2, 1, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_XOR, 0, 11, 3, 1, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_NOR, 0, 12, 31, 31, 16'h0000, 0), 0, '0},
			'{mk_instr(KIND_SLL, 0, 13, 3, 0, 16'h001F, 0), 0, '0},
			'{mk_instr(KIND_SRL, 0, 14, 13, 0, 16'h7FFF, 0), 0, '0},
			'{mk_instr(KIND_SRA, 0, 15, 13, 0, 16'hFFFF, 0), 0, '0},
			'{mk_instr(KIND_SW, 0, 0, 31, 0, 16'hFFFB, 0), 0, '0},
			'{mk_instr(KIND_LW, 0, 16, 31, 0, 16'hFFF9, 0), 0, '0},
			'{mk_instr(KIND_BEQ, 0, 3, 12, 0, 16'h0000, 10'd512), 0, '0},
			'{mk_instr(KIND_BEQ, 0, 1, 2, 0, 16'h0000, 10'd100), 0, '0},
			'{mk_instr(KIND_BNE, 0, 1, 2, 0, 16'h0000, 10'd1000), 0, '0},
			'{mk_instr(KIND_JR, 0, 1, 0, 0, 16'h0000, 0), 0, '0}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The first word also waits out the memory clearing pass after reset.
		foreach (dir_rows[i]) begin
			send_instr(dir_rows[i].w);
			predicted = execute_instr(dir_rows[i].w);
			pending_results.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
		end

		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			send_idle_pct = SEND_IDLE[ph];
			stall_pct     = RECV_STALL[ph];
			if (ph == 0) entry_pc = PC_W'(PROGRAM_DEPTH - 1);
			else if (ph == 1) entry_pc = '0;
			else entry_pc = PC_W'($urandom_range(PROGRAM_DEPTH - 2, 1));
			load_start_pc(entry_pc);
			repeat (PHASE_ITEMS) begin
				w = random_instr();
				send_instr(w);
				pending_results.push_back(execute_instr(w));
			end
		end
		drain_results();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
design/msx_pkg.sv
design/msx_stream_if.sv
design/msx_front.sv
design/msx_queue.sv
design/msx_regfile.sv
design/msx_back.sv
design/mips_subset_execute.sv
verif/mips_subset_execute_tb.sv
